/* src/stbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg: shared constants for the sorted table binary search
// Table geometry, field widths and transaction action codes.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // fixed field widths
  localparam int IDX_W  = 11;
  localparam int WORD_W = 32;

  // action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

endpackage
`default_nettype wire

/* src/stbs_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_table: table storage
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module stbs_table
  import stbs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [WORD_W-1:0] wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic signed [WORD_W-1:0]      rdata
);

  logic signed [WORD_W-1:0] mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/sorted_table_binary_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search: binary search over a loaded table
// Load transactions write one signed table word; search transactions halve
// an inclusive index range until the key is found or the range empties.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start, busy          action, entry_index, entry_value,
//                                 search_key, range_low, range_high
//  result    done (1-cycle)       found, position
//
//  a load writes the table word on acceptance; busy stays low and no result is produced.
//  an empty-range search answers in the cycle after acceptance.
//  otherwise busy is high while probing, at most ADDR_W+1 (12) probes,
//  each comparing the word read at the edge before; done follows the last.
//  rst is synchronous; the table itself is not cleared.
//  the receiver cannot stall; busy drops together with the done strobe.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     action,
  input  wire logic [IDX_W-1:0]         entry_index,
  input  wire logic signed [WORD_W-1:0] entry_value,
  input  wire logic signed [WORD_W-1:0] search_key,
  input  wire logic [IDX_W-1:0]         range_low,
  input  wire logic [IDX_W-1:0]         range_high,
  output logic                          done,
  output logic                          found,
  output logic [IDX_W-1:0]              position
);

  typedef enum logic {ST_IDLE, ST_PROBE} state_t;

  state_t                   state;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         hi;
  logic [IDX_W-1:0]         mid;
  logic signed [WORD_W-1:0] key;

  logic                     accept;
  logic                     we;
  logic                     re;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [WORD_W-1:0] rdata;

  logic [IDX_W-1:0]         hi_sat;
  logic                     start_empty;
  logic [IDX_W-1:0]         start_mid;

  logic                     is_less;
  logic                     is_more;
  logic                     step_empty;
  logic [IDX_W-1:0]         lo_next;
  logic [IDX_W-1:0]         hi_next;
  logic [IDX_W-1:0]         mid_next;
  logic [IDX_W:0]           start_sum;
  logic [IDX_W:0]           step_sum;

  assign accept = start && !busy;

  // load path: writes beyond the table are dropped
  assign we = accept && (action == ACT_LOAD) &&
              (32'(entry_index) < 32'(TABLE_DEPTH));

  // search setup: saturate the range and take the first midpoint
  always_comb begin
    if (32'(range_high) > 32'(TABLE_DEPTH - 1)) begin
      hi_sat = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      hi_sat = range_high;
    end
    start_empty = (range_low > hi_sat);
    start_sum   = {1'b0, range_low} + {1'b0, hi_sat};
    start_mid   = start_sum[IDX_W:1];
  end

  // probe step: compare the read word, narrow the range, next midpoint
  always_comb begin
    is_less    = (rdata < key);
    is_more    = (rdata > key);
    lo_next    = lo;
    hi_next    = hi;
    step_empty = 1'b0;
    if (is_less) begin
      lo_next    = mid + IDX_W'(1);
      step_empty = (mid == hi);
    end else if (is_more) begin
      hi_next    = mid - IDX_W'(1);
      step_empty = (mid == lo);
    end
    step_sum = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = step_sum[IDX_W:1];
  end

  // table read issue
  always_comb begin
    re     = 1'b0;
    rd_idx = start_mid;
    if (state == ST_IDLE) begin
      re     = accept && (action == ACT_SEARCH) && !start_empty;
      rd_idx = start_mid;
    end else begin
      re     = (is_less || is_more) && !step_empty;
      rd_idx = mid_next;
    end
  end

  stbs_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (ADDR_W'(entry_index)),
    .wdata (entry_value),
    .re    (re),
    .raddr (ADDR_W'(rd_idx)),
    .rdata (rdata)
  );

  // search sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      busy     <= 1'b0;
      done     <= 1'b0;
      found    <= 1'b0;
      position <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (action == ACT_SEARCH)) begin
            key <= search_key;
            if (start_empty) begin
              done     <= 1'b1;
              found    <= 1'b0;
              position <= '0;
            end else begin
              lo    <= range_low;
              hi    <= hi_sat;
              mid   <= start_mid;
              busy  <= 1'b1;
              state <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (!is_less && !is_more) begin
            done     <= 1'b1;
            found    <= 1'b1;
            position <= mid;
            busy     <= 1'b0;
            state    <= ST_IDLE;
          end else if (step_empty) begin
            done     <= 1'b1;
            found    <= 1'b0;
            position <= '0;
            busy     <= 1'b0;
            state    <= ST_IDLE;
          end else begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= mid_next;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // no result is shown while a search is still probing
  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("done asserted while busy");

  // a finished search always produces a result strobe
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("search ended without result");

  // an empty range answers not found on the next cycle
  a_empty_range: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == ACT_SEARCH) && start_empty) |=> (done && !found))
    else $error("empty range not answered at once");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (position == '0))
    else $error("nonzero position on miss");

  // the live range never inverts while probing
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((lo <= mid) && (mid <= hi)))
    else $error("probe outside live range");
`endif

endmodule
`default_nettype wire
